// File: sv/fbd_pkg.sv
// Shared constants, types and address helper for the framebuffer draw engine.
package fbd_pkg;

   localparam int SCREEN_COLUMNS   = 128;
   localparam int SCREEN_ROWS      = 32;
   localparam int SPRITE_MAX_WIDTH = 32;

   localparam int BANK_COLUMNS = 32;
   localparam int BANK_BYTES   = ((SCREEN_ROWS + 7) / 8) * BANK_COLUMNS;
   localparam int BANK_COUNT   = (SCREEN_COLUMNS + BANK_COLUMNS - 1) / BANK_COLUMNS;
   localparam int STORE_BYTES  = BANK_COUNT * BANK_BYTES;
   localparam int ADDR_W       = $clog2(STORE_BYTES);

   localparam int COL_W  = $clog2(SCREEN_COLUMNS);
   localparam int ROW_W  = $clog2(SCREEN_ROWS);
   localparam int SPAN_W = (COL_W > ROW_W) ? COL_W : ROW_W;

   localparam int SPRITE_LIMIT = (SPRITE_MAX_WIDTH < 32) ? SPRITE_MAX_WIDTH : 32;

   localparam int COORD_W  = 12;
   localparam int SPRITE_W = COORD_W + 2;

   localparam logic [7:0] BLANK_BYTE = 8'hFF;

   typedef enum logic [2:0] {
      OP_PLOT   = 3'd0,
      OP_HSPAN  = 3'd1,
      OP_VSPAN  = 3'd2,
      OP_RECT   = 3'd3,
      OP_SPRITE = 3'd4,
      OP_CLEAR  = 3'd5,
      OP_READ   = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_RUN,
      ST_SPRITE,
      ST_READ,
      ST_RDATA,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]                op;
      logic signed [COORD_W-1:0] x_a;
      logic signed [COORD_W-1:0] y_a;
      logic signed [COORD_W-1:0] x_b;
      logic signed [COORD_W-1:0] y_b;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic [4:0]                row_number;
      logic [31:0]               row_bits;
      logic [5:0]                row_width;
      logic [8:0]                read_address;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        mask;
   } px_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
   } fill_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   function automatic logic [ADDR_W-1:0] pixel_addr(input logic [COL_W-1:0] x,
                                                    input logic [ROW_W-1:0] y);
      logic [ADDR_W-1:0] bank;
      logic [ADDR_W-1:0] band;
      logic [ADDR_W-1:0] col;
      bank = ADDR_W'(x / BANK_COLUMNS);
      band = ADDR_W'(y / 8);
      col  = ADDR_W'(x % BANK_COLUMNS);
      return ADDR_W'(bank * ADDR_W'(BANK_BYTES)) + ADDR_W'(band * ADDR_W'(BANK_COLUMNS)) + col;
   endfunction

endpackage

// File: sv/fbd_req_if.sv
// Request channel interface of the framebuffer draw engine.
interface fbd_req_if;
   logic             valid;
   logic             ready;
   fbd_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: sv/fbd_rsp_if.sv
// Response channel interface of the framebuffer draw engine.
interface fbd_rsp_if;
   logic             valid;
   logic             ready;
   fbd_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: sv/fbd_store.sv
// Pixel byte store: one write port and one registered read port.
module fbd_store (
   input  logic                         clock,
   input  fbd_pkg::wr_type              wr,
   input  logic [fbd_pkg::ADDR_W-1:0]   rd_addr,
   output logic [7:0]                   rd_data
);

   logic [7:0] mem_ff [fbd_pkg::STORE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/fbd_rmw.sv
// Read-modify-write stage that clears pixel bits, with forwarding of the previous write, and blank fill writes.
module fbd_rmw (
   input  logic                clock,
   input  logic                reset,
   input  fbd_pkg::px_type     px,
   input  fbd_pkg::fill_type   fill,
   input  logic [7:0]          rd_data,
   output fbd_pkg::wr_type     wr
);

   logic                       s1_valid_ff, s1_valid_in;
   logic [fbd_pkg::ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic [7:0]                 s1_mask_ff, s1_mask_in;
   logic                       last_valid_ff, last_valid_in;
   logic [fbd_pkg::ADDR_W-1:0] last_addr_ff, last_addr_in;
   logic [7:0]                 last_data_ff, last_data_in;
   logic [7:0]                 merged;

   // The byte written in the previous cycle is not yet visible in the read data.
   always_comb begin
      merged = ((last_valid_ff && (last_addr_ff == s1_addr_ff)) ? last_data_ff : rd_data)
               & ~s1_mask_ff;
      s1_valid_in   = px.valid;
      s1_addr_in    = px.addr;
      s1_mask_in    = px.mask;
      last_valid_in = s1_valid_ff;
      last_addr_in  = s1_addr_ff;
      last_data_in  = merged;
      if (fill.valid) begin
         wr.en   = 1'b1;
         wr.addr = fill.addr;
         wr.data = fbd_pkg::BLANK_BYTE;
      end else begin
         wr.en   = s1_valid_ff;
         wr.addr = s1_addr_ff;
         wr.data = merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         last_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         last_valid_ff <= last_valid_in;
      end
      s1_addr_ff   <= s1_addr_in;
      s1_mask_ff   <= s1_mask_in;
      last_addr_ff <= last_addr_in;
      last_data_ff <= last_data_in;
   end

endmodule

// File: sv/fbd_seq.sv
// Operation sequencer: span clipping, pixel walk, sprite walk, clear sweep, reads, response.
module fbd_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  fbd_pkg::req_type             req,
   input  logic                         req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_data,
   output fbd_pkg::px_type              px,
   output fbd_pkg::fill_type            fill,
   output logic [fbd_pkg::ADDR_W-1:0]   rd_addr,
   input  logic [7:0]                   rd_data
);

   localparam int CW = fbd_pkg::COORD_W;
   localparam int SW = fbd_pkg::SPAN_W;
   localparam int PW = fbd_pkg::SPRITE_W;
   localparam int AW = fbd_pkg::ADDR_W;

   fbd_pkg::state_type    state_ff, state_in;
   fbd_pkg::op_type       op_ff, op_in;
   logic signed [CW-1:0]  x_a_ff, x_a_in, y_a_ff, y_a_in, x_b_ff, x_b_in, y_b_ff, y_b_in;
   logic signed [PW-1:0]  spr_x_ff, spr_x_in, spr_y_ff, spr_y_in;
   logic [31:0]           bits_ff, bits_in;
   logic [5:0]            width_ff, width_in;
   logic [5:0]            sx_ff, sx_in;
   logic [AW-1:0]         raddr_ff, raddr_in;
   logic [AW-1:0]         fill_ff, fill_in;
   logic                  clear_rsp_ff, clear_rsp_in;
   logic [1:0]            seg_ff, seg_in;
   logic                  horiz_ff, horiz_in;
   logic [SW-1:0]         fixed_ff, fixed_in, cur_ff, cur_in, end_ff, end_in;
   logic [7:0]            result_ff, result_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff, rsp_data_in;

   logic                  last_seg;
   logic                  seg_horiz;
   logic signed [CW-1:0]  seg_a, seg_b, seg_f, seg_lo, seg_hi, seg_lo_c, seg_hi_c;
   logic signed [CW-1:0]  var_lim, fix_lim;
   logic                  seg_empty;
   logic signed [PW-1:0]  spr_px;
   logic                  spr_y_on;
   logic [fbd_pkg::COL_W-1:0] pix_x;
   logic [fbd_pkg::ROW_W-1:0] pix_y;

   always_comb begin
      // Segment geometry; rectangle segments are top, bottom, left, right.
      last_seg  = (op_ff != fbd_pkg::OP_RECT) || (&seg_ff);
      seg_horiz = !((op_ff == fbd_pkg::OP_VSPAN) || ((op_ff == fbd_pkg::OP_RECT) && seg_ff[1]));
      if (seg_horiz) begin
         seg_a = x_a_ff;
         seg_b = (op_ff == fbd_pkg::OP_PLOT) ? x_a_ff : x_b_ff;
         seg_f = ((op_ff == fbd_pkg::OP_RECT) && seg_ff[0]) ? y_b_ff : y_a_ff;
         var_lim = CW'(fbd_pkg::SCREEN_COLUMNS - 1);
         fix_lim = CW'(fbd_pkg::SCREEN_ROWS - 1);
      end else begin
         seg_a = y_a_ff;
         seg_b = y_b_ff;
         seg_f = ((op_ff == fbd_pkg::OP_RECT) && seg_ff[0]) ? x_b_ff : x_a_ff;
         var_lim = CW'(fbd_pkg::SCREEN_ROWS - 1);
         fix_lim = CW'(fbd_pkg::SCREEN_COLUMNS - 1);
      end
      seg_lo    = (seg_a > seg_b) ? seg_b : seg_a;
      seg_hi    = (seg_a > seg_b) ? seg_a : seg_b;
      seg_lo_c  = (seg_lo < 0) ? CW'(0) : seg_lo;
      seg_hi_c  = (seg_hi > var_lim) ? var_lim : seg_hi;
      seg_empty = (seg_f < 0) || (seg_f > fix_lim) || (seg_lo_c > seg_hi_c);

      spr_px   = spr_x_ff + $signed(PW'(sx_ff));
      spr_y_on = (spr_y_ff >= 0) && (spr_y_ff < fbd_pkg::SCREEN_ROWS);

      if (state_ff == fbd_pkg::ST_SPRITE) begin
         pix_x = spr_px[fbd_pkg::COL_W-1:0];
         pix_y = spr_y_ff[fbd_pkg::ROW_W-1:0];
      end else if (horiz_ff) begin
         pix_x = cur_ff[fbd_pkg::COL_W-1:0];
         pix_y = fixed_ff[fbd_pkg::ROW_W-1:0];
      end else begin
         pix_x = fixed_ff[fbd_pkg::COL_W-1:0];
         pix_y = cur_ff[fbd_pkg::ROW_W-1:0];
      end
      px.valid = 1'b0;
      px.addr  = fbd_pkg::pixel_addr(pix_x, pix_y);
      px.mask  = 8'(1) << pix_y[2:0];
      fill.valid = 1'b0;
      fill.addr  = fill_ff;
      rd_addr    = px.addr;
      req_ready  = (state_ff == fbd_pkg::ST_IDLE);

      state_in     = state_ff;
      op_in        = op_ff;
      x_a_in       = x_a_ff;
      y_a_in       = y_a_ff;
      x_b_in       = x_b_ff;
      y_b_in       = y_b_ff;
      spr_x_in     = spr_x_ff;
      spr_y_in     = spr_y_ff;
      bits_in      = bits_ff;
      width_in     = width_ff;
      sx_in        = sx_ff;
      raddr_in     = raddr_ff;
      fill_in      = fill_ff;
      clear_rsp_in = clear_rsp_ff;
      seg_in       = seg_ff;
      horiz_in     = horiz_ff;
      fixed_in     = fixed_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         fbd_pkg::ST_CLEAR: begin
            fill.valid = 1'b1;
            if (fill_ff == AW'(fbd_pkg::STORE_BYTES - 1)) begin
               state_in = clear_rsp_ff ? fbd_pkg::ST_DONE : fbd_pkg::ST_IDLE;
            end else begin
               fill_in = fill_ff + AW'(1);
            end
         end
         fbd_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in     = fbd_pkg::op_type'(req.op);
               x_a_in    = req.x_a;
               y_a_in    = req.y_a;
               x_b_in    = req.x_b;
               y_b_in    = req.y_b;
               spr_x_in  = PW'(req.x_a) - PW'(req.origin_x);
               spr_y_in  = PW'(req.y_a) + PW'(req.row_number) - PW'(req.origin_y);
               bits_in   = req.row_bits;
               width_in  = (req.row_width > fbd_pkg::SPRITE_LIMIT) ?
                           6'(fbd_pkg::SPRITE_LIMIT) : req.row_width;
               sx_in     = '0;
               seg_in    = '0;
               raddr_in  = AW'(req.read_address);
               result_in = '0;
               unique case (fbd_pkg::op_type'(req.op))
                  fbd_pkg::OP_PLOT, fbd_pkg::OP_HSPAN, fbd_pkg::OP_VSPAN,
                  fbd_pkg::OP_RECT: begin
                     state_in = fbd_pkg::ST_SETUP;
                  end
                  fbd_pkg::OP_SPRITE: begin
                     state_in = fbd_pkg::ST_SPRITE;
                  end
                  fbd_pkg::OP_CLEAR: begin
                     state_in     = fbd_pkg::ST_CLEAR;
                     fill_in      = '0;
                     clear_rsp_in = 1'b1;
                  end
                  fbd_pkg::OP_READ: begin
                     state_in = (32'(req.read_address) < fbd_pkg::STORE_BYTES) ?
                                fbd_pkg::ST_READ : fbd_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = fbd_pkg::ST_DONE;
                  end
               endcase
            end
         end
         fbd_pkg::ST_SETUP: begin
            horiz_in = seg_horiz;
            fixed_in = seg_f[SW-1:0];
            cur_in   = seg_lo_c[SW-1:0];
            end_in   = seg_hi_c[SW-1:0];
            if (!seg_empty) begin
               state_in = fbd_pkg::ST_RUN;
            end else if (last_seg) begin
               state_in = fbd_pkg::ST_DONE;
            end else begin
               seg_in = seg_ff + 2'(1);
            end
         end
         fbd_pkg::ST_RUN: begin
            px.valid = 1'b1;
            if (cur_ff != end_ff) begin
               cur_in = cur_ff + SW'(1);
            end else if (last_seg) begin
               state_in = fbd_pkg::ST_DONE;
            end else begin
               seg_in   = seg_ff + 2'(1);
               state_in = fbd_pkg::ST_SETUP;
            end
         end
         fbd_pkg::ST_SPRITE: begin
            if (sx_ff == width_ff) begin
               state_in = fbd_pkg::ST_DONE;
            end else begin
               px.valid = bits_ff[sx_ff[4:0]] && spr_y_on && (spr_px >= 0) &&
                          (spr_px < fbd_pkg::SCREEN_COLUMNS);
               sx_in    = sx_ff + 6'(1);
            end
         end
         fbd_pkg::ST_READ: begin
            rd_addr  = raddr_ff;
            state_in = fbd_pkg::ST_RDATA;
         end
         fbd_pkg::ST_RDATA: begin
            result_in = rd_data;
            state_in  = fbd_pkg::ST_DONE;
         end
         fbd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = fbd_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbd_pkg::ST_CLEAR;
         fill_ff      <= '0;
         clear_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         clear_rsp_ff <= clear_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      x_a_ff      <= x_a_in;
      y_a_ff      <= y_a_in;
      x_b_ff      <= x_b_in;
      y_b_ff      <= y_b_in;
      spr_x_ff    <= spr_x_in;
      spr_y_ff    <= spr_y_in;
      bits_ff     <= bits_in;
      width_ff    <= width_in;
      sx_ff       <= sx_in;
      raddr_ff    <= raddr_in;
      seg_ff      <= seg_in;
      horiz_ff    <= horiz_in;
      fixed_ff    <= fixed_in;
      cur_ff      <= cur_in;
      end_ff      <= end_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sv/mono_framebuffer_draw_engine_unit.sv
// Top level of the monochrome framebuffer draw engine.
//
//   channel   direction  payload                                   handshake
//   req_bus   in         op, coordinates, sprite row, read address  valid/ready
//   rsp_bus   out        read_data                                  valid/ready
//
// One request is worked at a time, one pixel per cycle through the store read-modify-write.
// A plot or span runs setup and then its clipped pixels, a rectangle does so for each of its
// four spans, a sprite row walks its width, a read passes the read and read-data states, and
// a clear sweeps all STORE_BYTES (512) bytes to blank; so does reset, with ready low.
// A finished response waits in the output register; the next request is still taken, and
// its own completion waits only while that register is still full.
module mono_framebuffer_draw_engine_unit (
   input  logic       clock,
   input  logic       reset,
   fbd_req_if.sink    req_bus,
   fbd_rsp_if.source  rsp_bus
);

   fbd_pkg::px_type              px;
   fbd_pkg::fill_type            fill;
   fbd_pkg::wr_type              wr;
   logic [fbd_pkg::ADDR_W-1:0]   rd_addr;
   logic [7:0]                   rd_data;

   fbd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus.data),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_bus.data.read_data),
      .px        (px),
      .fill      (fill),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   fbd_rmw u_rmw (
      .clock   (clock),
      .reset   (reset),
      .px      (px),
      .fill    (fill),
      .rd_data (rd_data),
      .wr      (wr)
   );

   fbd_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// File: sv/fbd_checker.sv
// Port-level checks of the framebuffer draw engine and their binding to the top level.
module fbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data
);

   // Reset starts the blanking sweep, so nothing is taken or offered right after it.
   assert property (@(posedge clock) reset |=> !req_ready && !rsp_valid)
      else $error("engine not quiet after reset");

   // Requests are worked one at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while one is in progress");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed or dropped");

endmodule

bind mono_framebuffer_draw_engine_unit fbd_checker u_fbd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.data.read_data)
);
